>>> sv/ttsr_pkg.sv
// Shared widths, constants, codes and pipeline types of the twist to speed/radius core.
package ttsr_pkg;

   // Field and register widths
   localparam int VX_W       = 16;
   localparam int WZ_W       = 20;
   localparam int TRACK_W    = 12;
   localparam int DZ_W       = 10;
   localparam int MINS_W     = 10;
   localparam int OUT_W      = 16;
   localparam int CASE_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   // Register reset values
   localparam logic [TRACK_W-1:0] TRACK_RESET = 12'd485;
   localparam logic [DZ_W-1:0]    DZ_RESET    = 10'd100;
   localparam logic [MINS_W-1:0]  MINS_RESET  = 10'd50;

   // Arithmetic widths
   localparam int QUO_BITS = 16;                // radius quotient bits
   localparam int NUM_W    = 29;                // |vx| * 10000
   localparam int PROD_W   = 31;                // track * |wz|
   localparam int PRE_SH   = 5;                 // 20000 = 32 * 625
   localparam int X_W      = PROD_W - PRE_SH;   // track * |wz| / 32
   localparam int RECIP_W  = 27;
   localparam int RECIP_SH = 36;
   localparam int RPROD_W  = X_W + RECIP_W;
   localparam int QT_W     = RPROD_W - RECIP_SH; // track * |wz| / 20000
   localparam int P625_W   = 27;
   localparam int CMP_W    = WZ_W + QUO_BITS;
   localparam int SAT_W    = 18;

   localparam logic [13:0]        RADIUS_SCALE = 14'd10000;
   localparam logic [RECIP_W-1:0] RECIP_625    = 27'd109951162; // floor(2^36 / 625)
   localparam logic [9:0]         DIV_625      = 10'd625;

   // Pipeline depths
   localparam int FRONT_STAGES = 5;
   localparam int DIV_STAGES   = QUO_BITS + 1;

   typedef enum logic [CASE_W-1:0] {
      CASE_STRAIGHT = 2'd0,
      CASE_SPIN     = 2'd1,
      CASE_ARC      = 2'd2
   } ttsr_case_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TRACK     = 2'd0,
      CSR_DEAD_ZONE = 2'd1,
      CSR_MIN_SPIN  = 2'd2
   } ttsr_csr_type;

   typedef struct packed {
      logic                 vx_neg;
      logic                 vx_zero;
      logic [VX_W-1:0]      vx_mag;
      logic                 wz_neg;
      logic                 wz_zero;
      logic [WZ_W-1:0]      wz_mag;
      ttsr_case_type        dcase;
      logic [NUM_W-1:0]     num;
      logic [PROD_W-1:0]    prod;
      logic [RPROD_W-1:0]   rprod;
      logic [QT_W-1:0]      quo_t;
      logic [P625_W-1:0]    p625;
      logic                 ovf;
      logic [QUO_BITS-1:0]  quo_r;
   } ttsr_item_type;

   typedef struct packed {
      logic          valid;
      ttsr_item_type item;
   } ttsr_stage_type;

endpackage

>>> sv/ttsr_if.sv
// Valid/ready channel interfaces: command input, result output and register write port.
interface ttsr_req_if;
   import ttsr_pkg::*;
   logic                   valid;
   logic                   ready;
   logic signed [VX_W-1:0] linear_velocity;
   logic signed [WZ_W-1:0] angular_rate;
   modport source (output valid, linear_velocity, angular_rate, input ready);
   modport sink   (input valid, linear_velocity, angular_rate, output ready);
endinterface

interface ttsr_rsp_if;
   import ttsr_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] speed_cmd;
   logic signed [OUT_W-1:0] radius_cmd;
   logic [CASE_W-1:0]       drive_case;
   modport source (output valid, speed_cmd, radius_cmd, drive_case, input ready);
   modport sink   (input valid, speed_cmd, radius_cmd, drive_case, output ready);
endinterface

interface ttsr_csr_if;
   import ttsr_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

>>> sv/twist_to_speed_radius_command_core.sv
// Top level of the twist to speed/radius command core: registers and pipeline hookup.
//
// Converts a linear velocity (mm/s) and yaw rate (1e-4 rad/s) into a wheel speed
// (mm/s), turn radius (mm) and drive case (straight, spin in place, arc).
// Channels: req_ch takes command items, rsp_ch delivers one result item per command,
// csr_ch writes track width, dead zone and minimum spin speed (index 0, 1, 2); it is
// always ready and ignores unknown indexes. Write registers only while no item is in
// flight.
// Pipeline: 23 register stages, in order: five front stages (dead zone, products,
// case pick, divide by 20000 through a reciprocal multiply and correction),
// seventeen divider stages (overflow check and one restoring radius quotient bit per
// stage) and the output register.
// Throughput: one item per cycle while no stall holds the pipeline; every stage
// takes a new item each cycle unless it is held.
// Stall: each stage holds while its successor is full and stalled, so bubbles close
// up and new items are accepted until the pipeline is full; nothing is lost.
// Reset clears all valid bits and loads the register defaults (485, 100, 50).
module twist_to_speed_radius_command_core (
   input  logic        clock,
   input  logic        reset,
   ttsr_req_if.sink    req_ch,
   ttsr_rsp_if.source  rsp_ch,
   ttsr_csr_if.sink    csr_ch
);
   import ttsr_pkg::*;

   logic [TRACK_W-1:0] track_ff;
   logic [DZ_W-1:0]    dz_ff;
   logic [MINS_W-1:0]  mins_ff;

   ttsr_stage_type     front_st;
   ttsr_stage_type     div_st;
   logic               front_en;
   logic               div_en;
   logic               back_en;

   // Register writes
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         track_ff <= TRACK_RESET;
         dz_ff    <= DZ_RESET;
         mins_ff  <= MINS_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_TRACK:     track_ff <= csr_ch.wdata[TRACK_W-1:0];
            CSR_DEAD_ZONE: dz_ff    <= csr_ch.wdata[DZ_W-1:0];
            CSR_MIN_SPIN:  mins_ff  <= csr_ch.wdata[MINS_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_ch.ready = front_en;

   ttsr_front u_front (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (req_ch.valid),
      .linear_velocity (req_ch.linear_velocity),
      .angular_rate    (req_ch.angular_rate),
      .track_width     (track_ff),
      .dead_zone       (dz_ff),
      .en_dn           (div_en),
      .en_up           (front_en),
      .out_st          (front_st)
   );

   ttsr_div u_div (
      .clock  (clock),
      .reset  (reset),
      .in_st  (front_st),
      .en_dn  (back_en),
      .en_up  (div_en),
      .out_st (div_st)
   );

   ttsr_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_st    (div_st),
      .min_spin (mins_ff),
      .en_up    (back_en),
      .rsp_ch   (rsp_ch)
   );

endmodule

>>> sv/ttsr_front.sv
// Front pipeline: dead zone, magnitudes, products, case decision and track term / 20000.
module ttsr_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic signed [ttsr_pkg::VX_W-1:0] linear_velocity,
   input  logic signed [ttsr_pkg::WZ_W-1:0] angular_rate,
   input  logic [ttsr_pkg::TRACK_W-1:0]   track_width,
   input  logic [ttsr_pkg::DZ_W-1:0]      dead_zone,
   input  logic                           en_dn,
   output logic                           en_up,
   output ttsr_pkg::ttsr_stage_type       out_st
);
   import ttsr_pkg::*;

   localparam int LAST = FRONT_STAGES - 1;

   logic [FRONT_STAGES-1:0] valid_ff;
   logic [FRONT_STAGES-1:0] en;
   ttsr_item_type           item_ff [FRONT_STAGES];
   ttsr_item_type           item_in [FRONT_STAGES];

   // Stage enables: a stage moves when empty or when the next one moves
   genvar g;
   generate
      for (g = 0; g < LAST; g++) begin : g_en
         assign en[g] = !valid_ff[g] || en[g+1];
      end
   endgenerate
   assign en[LAST] = !valid_ff[LAST] || en_dn;
   assign en_up    = en[0];

   // Per-stage work
   always_comb begin
      logic [VX_W-1:0]    vx_abs;
      logic [WZ_W-1:0]    wz_abs;
      logic               below_dz;
      logic [29:0]        nprod;
      logic [31:0]        tprod;
      logic [RPROD_W-1:0] rp;
      logic [X_W-1:0]     x;
      logic [P625_W-1:0]  rem;

      // stage 0: magnitudes and dead zone
      vx_abs = linear_velocity[VX_W-1] ? VX_W'(-linear_velocity) : VX_W'(linear_velocity);
      wz_abs = angular_rate[WZ_W-1] ? WZ_W'(-angular_rate) : WZ_W'(angular_rate);
      below_dz = vx_abs < {{(VX_W-DZ_W){1'b0}}, dead_zone};
      item_in[0]         = '0;
      item_in[0].vx_zero = below_dz || (vx_abs == '0);
      item_in[0].vx_neg  = linear_velocity[VX_W-1] && !below_dz;
      item_in[0].vx_mag  = below_dz ? '0 : vx_abs;
      item_in[0].wz_neg  = angular_rate[WZ_W-1];
      item_in[0].wz_zero = (angular_rate == '0);
      item_in[0].wz_mag  = wz_abs;

      // stage 1: |vx| * 10000 and track * |wz|
      item_in[1]      = item_ff[0];
      nprod           = 30'(item_ff[0].vx_mag) * 30'(RADIUS_SCALE);
      tprod           = 32'(track_width) * 32'(item_ff[0].wz_mag);
      item_in[1].num  = nprod[NUM_W-1:0];
      item_in[1].prod = tprod[PROD_W-1:0];

      // stage 2: pick the case, start the divide by 625
      item_in[2] = item_ff[1];
      if (item_ff[1].wz_zero) begin
         item_in[2].dcase = CASE_STRAIGHT;
      end else if (item_ff[1].vx_zero ||
                   item_ff[1].num <= {{(NUM_W-WZ_W){1'b0}}, item_ff[1].wz_mag}) begin
         item_in[2].dcase = CASE_SPIN;
      end else begin
         item_in[2].dcase = CASE_ARC;
      end
      x  = item_ff[1].prod[PROD_W-1:PRE_SH];
      rp = RPROD_W'(x) * RPROD_W'(RECIP_625);
      item_in[2].rprod = rp;

      // stage 3: estimate quotient, form its product with 625
      item_in[3]       = item_ff[2];
      item_in[3].quo_t = item_ff[2].rprod[RPROD_W-1:RECIP_SH];
      item_in[3].p625  = P625_W'(item_ff[2].rprod[RPROD_W-1:RECIP_SH]) * P625_W'(DIV_625);

      // stage 4: correct the estimate by one where the remainder is too large
      item_in[4] = item_ff[3];
      rem = P625_W'(item_ff[3].prod[PROD_W-1:PRE_SH]) - item_ff[3].p625;
      if (rem >= P625_W'(DIV_625)) begin
         item_in[4].quo_t = item_ff[3].quo_t + QT_W'(1);
      end
   end

   // Stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int i = 1; i < FRONT_STAGES; i++) begin
            if (en[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0] && in_valid) begin
         item_ff[0] <= item_in[0];
      end
      for (int i = 1; i < FRONT_STAGES; i++) begin
         if (en[i] && valid_ff[i-1]) begin
            item_ff[i] <= item_in[i];
         end
      end
   end

   assign out_st.valid = valid_ff[LAST];
   assign out_st.item  = item_ff[LAST];

endmodule

>>> sv/ttsr_div.sv
// Radius divider: overflow check, then one restoring quotient bit per pipeline stage.
module ttsr_div (
   input  logic                     clock,
   input  logic                     reset,
   input  ttsr_pkg::ttsr_stage_type in_st,
   input  logic                     en_dn,
   output logic                     en_up,
   output ttsr_pkg::ttsr_stage_type out_st
);
   import ttsr_pkg::*;

   localparam int LAST = DIV_STAGES - 1;

   logic [DIV_STAGES-1:0] valid_ff;
   logic [DIV_STAGES-1:0] en;
   ttsr_item_type         item_ff [DIV_STAGES];
   ttsr_item_type         item_in [DIV_STAGES];

   // One restoring step: subtract divisor << sh where it fits
   function automatic ttsr_item_type div_step(input ttsr_item_type it, input logic [3:0] sh);
      logic [CMP_W-1:0] dsh;
      logic [CMP_W-1:0] rem;
      ttsr_item_type    o;
      o   = it;
      dsh = CMP_W'(it.wz_mag) << sh;
      rem = CMP_W'(it.num);
      if (rem >= dsh) begin
         o.num       = NUM_W'(rem - dsh);
         o.quo_r[sh] = 1'b1;
      end else begin
         o.quo_r[sh] = 1'b0;
      end
      return o;
   endfunction

   // Quotient that needs more than the kept bits saturates later
   always_comb begin
      item_in[0]     = in_st.item;
      item_in[0].ovf = CMP_W'(in_st.item.num) >= {in_st.item.wz_mag, {QUO_BITS{1'b0}}};
   end

   genvar g;
   generate
      for (g = 1; g < DIV_STAGES; g++) begin : g_step
         assign item_in[g] = div_step(item_ff[g-1], 4'(QUO_BITS - g));
      end
      for (g = 0; g < LAST; g++) begin : g_en
         assign en[g] = !valid_ff[g] || en[g+1];
      end
   endgenerate
   assign en[LAST] = !valid_ff[LAST] || en_dn;
   assign en_up    = en[0];

   // Stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) begin
            valid_ff[0] <= in_st.valid;
         end
         for (int i = 1; i < DIV_STAGES; i++) begin
            if (en[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0] && in_st.valid) begin
         item_ff[0] <= item_in[0];
      end
      for (int i = 1; i < DIV_STAGES; i++) begin
         if (en[i] && valid_ff[i-1]) begin
            item_ff[i] <= item_in[i];
         end
      end
   end

   assign out_st.valid = valid_ff[LAST];
   assign out_st.item  = item_ff[LAST];

endmodule

>>> sv/ttsr_back.sv
// Output stage: apply signs, minimum spin speed and saturation, hold the result item.
module ttsr_back (
   input  logic                     clock,
   input  logic                     reset,
   input  ttsr_pkg::ttsr_stage_type in_st,
   input  logic [ttsr_pkg::MINS_W-1:0] min_spin,
   output logic                     en_up,
   ttsr_rsp_if.source               rsp_ch
);
   import ttsr_pkg::*;

   logic              valid_ff;
   logic [OUT_W-1:0]  speed_ff, speed_in;
   logic [OUT_W-1:0]  radius_ff, radius_in;
   ttsr_case_type     case_ff;
   logic              en;

   // Signed result from magnitude and sign, clamped to 16-bit range
   function automatic logic [OUT_W-1:0] saturate(input logic [SAT_W-1:0] m, input logic neg);
      logic [SAT_W-1:0] n;
      n = ~m + SAT_W'(1);
      if (neg) begin
         if (m >= SAT_W'(32768)) return 16'h8000;
         else return n[OUT_W-1:0];
      end else begin
         if (m >= SAT_W'(32767)) return 16'h7FFF;
         else return m[OUT_W-1:0];
      end
   endfunction

   always_comb begin
      logic [SAT_W-1:0] spin_mag;
      logic [SAT_W-1:0] arc_mag;
      logic [SAT_W-1:0] rad_mag;
      spin_mag = (in_st.item.quo_t < QT_W'(min_spin)) ? SAT_W'(min_spin)
                                                      : SAT_W'(in_st.item.quo_t);
      arc_mag  = SAT_W'(in_st.item.vx_mag) + SAT_W'(in_st.item.quo_t);
      rad_mag  = in_st.item.ovf ? {SAT_W{1'b1}} : SAT_W'(in_st.item.quo_r);
      unique case (in_st.item.dcase)
         CASE_STRAIGHT: begin
            speed_in  = saturate(SAT_W'(in_st.item.vx_mag), in_st.item.vx_neg);
            radius_in = '0;
         end
         CASE_SPIN: begin
            speed_in  = saturate(spin_mag, in_st.item.wz_neg);
            radius_in = OUT_W'(1);
         end
         CASE_ARC: begin
            speed_in  = saturate(arc_mag, in_st.item.vx_neg);
            radius_in = saturate(rad_mag, in_st.item.vx_neg ^ in_st.item.wz_neg);
         end
         default: begin
            speed_in  = '0;
            radius_in = '0;
         end
      endcase
   end

   // Output register moves when empty or when the item is taken
   assign en    = !valid_ff || rsp_ch.ready;
   assign en_up = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_st.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en && in_st.valid) begin
         speed_ff  <= speed_in;
         radius_ff <= radius_in;
         case_ff   <= in_st.item.dcase;
      end
   end

   assign rsp_ch.valid      = valid_ff;
   assign rsp_ch.speed_cmd  = speed_ff;
   assign rsp_ch.radius_cmd = radius_ff;
   assign rsp_ch.drive_case = case_ff;

endmodule

>>> sv/ttsr_checker.sv
// Port-level checks of the twist to speed/radius core, bound to its top level.
module ttsr_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [ttsr_pkg::OUT_W-1:0]    speed_cmd,
   input logic [ttsr_pkg::OUT_W-1:0]    radius_cmd,
   input logic [ttsr_pkg::CASE_W-1:0]   drive_case
);
   import ttsr_pkg::*;

   // Straight drive always reports radius zero
   a_straight_radius: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && drive_case == CASE_STRAIGHT |-> radius_cmd == '0)
      else $error("straight item with nonzero radius");

   // Spin in place always reports radius one
   a_spin_radius: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && drive_case == CASE_SPIN |-> radius_cmd == OUT_W'(1))
      else $error("spin item with radius other than one");

   // A free output side leaves the whole pipeline free to take an item
   a_ready_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled while output is ready");

   // A stalled result item holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(speed_cmd) &&
                                  $stable(radius_cmd) && $stable(drive_case))
      else $error("stalled result item changed");

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item present after reset");

endmodule

bind twist_to_speed_radius_command_core ttsr_checker u_ttsr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .speed_cmd  (rsp_ch.speed_cmd),
   .radius_cmd (rsp_ch.radius_cmd),
   .drive_case (rsp_ch.drive_case)
);

>>> tb/twist_to_speed_radius_command_core_test.sv
// Self-checking testbench of the twist to speed/radius command core: directed table, then random phases.
module twist_to_speed_radius_command_core_test;
   import ttsr_pkg::*;

   localparam longint RADIUS_SCALE_MM = 10000;   // vx * 10000 / wz gives mm
   localparam longint TRACK_DIVISOR   = 20000;   // track * wz / 20000 gives mm/s
   localparam longint SAT_HIGH        = 32767;
   localparam longint SAT_LOW         = -32768;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_IDX = 2'd3;
   localparam int NUM_PHASES      = 10;
   localparam int ITEMS_PER_PHASE = 145;
   localparam int CYCLE_LIMIT     = 600000;
   localparam int DRAIN_CYCLES    = 40;

   typedef struct {
      logic signed [OUT_W-1:0] speed;
      logic signed [OUT_W-1:0] radius;
      ttsr_case_type           dcase;
   } drive_cmd_type;

   typedef enum logic {ROW_CMD, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type            kind;
      logic                    pinned;
      logic [CSR_IDX_W-1:0]    idx;
      logic [CSR_DATA_W-1:0]   wdata;
      logic signed [VX_W-1:0]  lin;
      logic signed [WZ_W-1:0]  ang;
      drive_cmd_type           want;
   } stim_row_type;

   logic clock;
   logic reset;

   ttsr_req_if req_ch();
   ttsr_rsp_if rsp_ch();
   ttsr_csr_if csr_ch();

   twist_to_speed_radius_command_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Local copy of the register file
   logic [TRACK_W-1:0] track_mm;
   logic [DZ_W-1:0]    dead_zone;
   logic [MINS_W-1:0]  min_spin;

   drive_cmd_type drive_cmd_q[$];
   stim_row_type  directed[$];
   drive_cmd_type pin_want;
   logic          pin_next;
   logic          calm;
   int            error_count;
   int            cycle_count;

   // Clock: 12 time unit period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic longint magnitude(longint x);
      return (x < 0) ? -x : x;
   endfunction

   function automatic logic signed [OUT_W-1:0] clamp16(longint x);
      if (x > SAT_HIGH) return SAT_HIGH[OUT_W-1:0];
      if (x < SAT_LOW) return SAT_LOW[OUT_W-1:0];
      return x[OUT_W-1:0];
   endfunction

   // Compute the wheel base command for one twist under the current registers
   function automatic drive_cmd_type twist_to_drive_cmd(logic signed [VX_W-1:0] lin,
                                                        logic signed [WZ_W-1:0] ang);
      longint        vx;
      longint        wz;
      longint        trk;
      longint        dz;
      longint        mins;
      longint        s;
      longint        spd;
      longint        rad;
      longint        term;
      drive_cmd_type r;
      vx   = lin;
      wz   = ang;
      trk  = track_mm;
      dz   = dead_zone;
      mins = min_spin;
      if (magnitude(vx) < dz) vx = 0;
      if (wz == 0) begin
         spd     = vx;
         rad     = 0;
         r.dcase = CASE_STRAIGHT;
      end else if (vx == 0 || magnitude(vx) * RADIUS_SCALE_MM <= magnitude(wz)) begin
         // spin in place, raised to the minimum magnitude
         s = (trk * wz) / TRACK_DIVISOR;
         if (magnitude(s) < mins) s = (wz > 0) ? mins : -mins;
         spd     = s;
         rad     = 1;
         r.dcase = CASE_SPIN;
      end else begin
         term = trk * wz;
         if ((vx > 0) != (wz > 0)) term = -term;
         rad     = (vx * RADIUS_SCALE_MM) / wz;
         spd     = (vx * TRACK_DIVISOR + term) / TRACK_DIVISOR;
         r.dcase = CASE_ARC;
      end
      r.speed  = clamp16(spd);
      r.radius = clamp16(rad);
      return r;
   endfunction

   function automatic stim_row_type cmd_row(int lin, int ang);
      stim_row_type r;
      r.kind          = ROW_CMD;
      r.idx           = '0;
      r.wdata         = '0;
      r.lin           = VX_W'(lin);
      r.ang           = WZ_W'(ang);
      r.pinned        = 1'b0;
      r.want.speed    = '0;
      r.want.radius   = '0;
      r.want.dcase    = CASE_STRAIGHT;
      return r;
   endfunction

   function automatic stim_row_type pinned_row(int lin, int ang, int spd, int rad,
                                               ttsr_case_type dcase);
      stim_row_type r;
      r             = cmd_row(lin, ang);
      r.pinned      = 1'b1;
      r.want.speed  = OUT_W'(spd);
      r.want.radius = OUT_W'(rad);
      r.want.dcase  = dcase;
      return r;
   endfunction

   function automatic stim_row_type csr_row(logic [CSR_IDX_W-1:0] idx, int wdata);
      stim_row_type r;
      r       = cmd_row(0, 0);
      r.kind  = ROW_CSR;
      r.idx   = idx;
      r.wdata = CSR_DATA_W'(wdata);
      return r;
   endfunction

   // Append one row to the directed table
   task automatic add_row(stim_row_type r);
      directed = {directed, r};
   endtask

   // Gap length: mostly none, some short, a few long; none at all while calm
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm) return 0;
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      error_count++;
   endtask

   // Offer one item; called and returning at a falling edge
   task automatic send_twist(logic signed [VX_W-1:0] lin, logic signed [WZ_W-1:0] ang);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.linear_velocity <= lin;
      req_ch.angular_rate    <= ang;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Write one register; the block must be idle
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] wdata);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.wdata <= wdata;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      case (idx)
         CSR_TRACK:     track_mm  = wdata[TRACK_W-1:0];
         CSR_DEAD_ZONE: dead_zone = wdata[DZ_W-1:0];
         CSR_MIN_SPIN:  min_spin  = wdata[MINS_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid <= 1'b0;
      @(negedge clock);
   endtask

   // Hold off new items until every expected result has come back
   task automatic settle_pipeline();
      req_ch.valid <= 1'b0;
      while (drive_cmd_q.size() != 0) @(negedge clock);
   endtask

   // Draw one random twist, biased toward the case boundaries
   task automatic pick_twist(output logic signed [VX_W-1:0] lin,
                             output logic signed [WZ_W-1:0] ang);
      int kind;
      int t;
      int m;
      int dzv;
      kind = $urandom_range(0, 9);
      dzv  = int'(dead_zone);
      case (kind)
         0, 1: begin
            lin = VX_W'($urandom);
            ang = WZ_W'($urandom);
         end
         2: begin
            lin = VX_W'($urandom);
            ang = '0;
         end
         3: begin
            t   = $urandom_range(0, 2 * dzv + 2);
            lin = VX_W'(t - dzv - 1);
            ang = WZ_W'($urandom);
         end
         4: begin
            lin = '0;
            ang = WZ_W'(($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 200) - 100);
         end
         5: begin
            // near the one millimetre spin boundary
            m = $urandom_range(1, 52);
            t = int'(m * RADIUS_SCALE_MM) + $urandom_range(0, 4) - 2;
            lin = VX_W'(($urandom_range(0, 1)) ? -m : m);
            ang = WZ_W'(($urandom_range(0, 1)) ? -t : t);
         end
         6: begin
            case ($urandom_range(0, 4))
               0: lin = 16'sh7fff;
               1: lin = 16'sh8000;
               2: lin = 16'sd1;
               3: lin = -16'sd1;
               default: lin = '0;
            endcase
            case ($urandom_range(0, 3))
               0: ang = 20'sh7ffff;
               1: ang = 20'sh80000;
               2: ang = 20'sd1;
               default: ang = -20'sd1;
            endcase
         end
         default: begin
            t   = $urandom_range(0, 6000);
            lin = VX_W'(t - 3000);
            t   = $urandom_range(0, 60000);
            ang = WZ_W'(t - 30000);
         end
      endcase
   endtask

   // Result side: stall at random
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   // Record the expected result of each accepted item
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         if (pin_next) drive_cmd_q = {drive_cmd_q, pin_want};
         else drive_cmd_q = {drive_cmd_q, twist_to_drive_cmd(req_ch.linear_velocity,
                                                               req_ch.angular_rate)};
      end
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      drive_cmd_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (drive_cmd_q.size() == 0) begin
            report_mismatch($sformatf("unexpected item speed %0d radius %0d case %0d",
                                      rsp_ch.speed_cmd, rsp_ch.radius_cmd,
                                      rsp_ch.drive_case));
         end else begin
            want = drive_cmd_q.pop_front();
            if (rsp_ch.speed_cmd !== want.speed)
               report_mismatch($sformatf("speed_cmd got %0d want %0d",
                                         rsp_ch.speed_cmd, want.speed));
            if (rsp_ch.radius_cmd !== want.radius)
               report_mismatch($sformatf("radius_cmd got %0d want %0d",
                                         rsp_ch.radius_cmd, want.radius));
            if (rsp_ch.drive_case !== want.dcase)
               report_mismatch($sformatf("drive_case got %0d want %s",
                                         rsp_ch.drive_case, want.dcase.name()));
         end
      end
   end

   // Cycle limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("twist_to_speed_radius_command_core_test: errors");
         $finish;
      end
   end

   initial begin
      logic signed [VX_W-1:0]  lin;
      logic signed [WZ_W-1:0]  ang;
      logic [CSR_DATA_W-1:0]   wdata;
      stim_row_type            row;
      clock                  = 1'b0;
      reset                  = 1'b1;
      req_ch.valid           = 1'b0;
      req_ch.linear_velocity = '0;
      req_ch.angular_rate    = '0;
      rsp_ch.ready           = 1'b0;
      csr_ch.valid           = 1'b0;
      csr_ch.index           = CSR_TRACK;
      csr_ch.wdata           = '0;
      track_mm               = TRACK_RESET;
      dead_zone              = DZ_RESET;
      min_spin               = MINS_RESET;
      pin_next               = 1'b0;
      pin_want.speed         = '0;
      pin_want.radius        = '0;
      pin_want.dcase         = CASE_STRAIGHT;
      calm                   = 1'b0;
      error_count            = 0;
      cycle_count            = 0;

      // Directed table: reset registers first, then the register extremes
      add_row(pinned_row(0, 0, 0, 0, CASE_STRAIGHT));
      add_row(pinned_row(32767, 0, 32767, 0, CASE_STRAIGHT));
      add_row(pinned_row(-32768, 0, -32768, 0, CASE_STRAIGHT));
      add_row(pinned_row(99, 0, 0, 0, CASE_STRAIGHT));
      add_row(pinned_row(-100, 0, -100, 0, CASE_STRAIGHT));
      add_row(pinned_row(0, 1, 50, 1, CASE_SPIN));
      add_row(pinned_row(0, -1, -50, 1, CASE_SPIN));
      add_row(cmd_row(0, 524287));
      add_row(cmd_row(99, -524288));
      add_row(pinned_row(32767, 1, 32767, 32767, CASE_ARC));
      add_row(pinned_row(-32768, 1, -32768, -32768, CASE_ARC));
      add_row(cmd_row(32767, -524288));
      add_row(cmd_row(-500, 2000));
      add_row(csr_row(CSR_DEAD_ZONE, 0));
      add_row(csr_row(CSR_TRACK, 4095));
      add_row(cmd_row(1, 10000));
      add_row(cmd_row(1, 9999));
      add_row(cmd_row(-1, -10000));
      add_row(cmd_row(52, 524287));
      add_row(cmd_row(32767, 524287));
      add_row(csr_row(CSR_MIN_SPIN, 1023));
      add_row(pinned_row(0, 1, 1023, 1, CASE_SPIN));
      add_row(cmd_row(0, -524288));
      add_row(csr_row(CSR_MIN_SPIN, 0));
      add_row(pinned_row(0, 1, 0, 1, CASE_SPIN));
      add_row(csr_row(CSR_DEAD_ZONE, 1023));
      add_row(cmd_row(1022, 5));
      add_row(cmd_row(-1023, 5));
      add_row(csr_row(CSR_TRACK, 0));
      add_row(pinned_row(0, 524287, 0, 1, CASE_SPIN));
      add_row(cmd_row(2000, -3));
      add_row(csr_row(CSR_UNUSED_IDX, 4095));
      add_row(pinned_row(0, 0, 0, 0, CASE_STRAIGHT));

      // Hold reset, then release it at a falling edge
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Walk the directed table
      foreach (directed[i]) begin
         row = directed[i];
         if (row.kind == ROW_CSR) begin
            settle_pipeline();
            write_reg(row.idx, row.wdata);
         end else begin
            pin_next = row.pinned;
            pin_want = row.want;
            send_twist(row.lin, row.ang);
         end
      end
      pin_next = 1'b0;

      // Random phases, each under its own register setting
      for (int p = 0; p < NUM_PHASES; p++) begin
         settle_pipeline();
         calm = (p % 3 == 2);
         case (p)
            0: begin
               write_reg(CSR_TRACK, 12'd4095);
               write_reg(CSR_DEAD_ZONE, 12'd0);
               write_reg(CSR_MIN_SPIN, 12'd1023);
            end
            1: begin
               write_reg(CSR_TRACK, 12'd1);
               write_reg(CSR_DEAD_ZONE, 12'd1023);
               write_reg(CSR_MIN_SPIN, 12'd0);
            end
            2: begin
               write_reg(CSR_TRACK, TRACK_RESET);
               write_reg(CSR_DEAD_ZONE, CSR_DATA_W'(DZ_RESET));
               write_reg(CSR_MIN_SPIN, CSR_DATA_W'(MINS_RESET));
            end
            default: begin
               write_reg(CSR_TRACK, CSR_DATA_W'($urandom_range(0, 4095)));
               // upper data bits are random and must be dropped by the block
               wdata = CSR_DATA_W'($urandom);
               case ($urandom_range(0, 2))
                  0: wdata[DZ_W-1:0] = '0;
                  1: wdata[DZ_W-1:0] = '1;
                  default: ;
               endcase
               write_reg(CSR_DEAD_ZONE, wdata);
               wdata = CSR_DATA_W'($urandom);
               case ($urandom_range(0, 2))
                  0: wdata[MINS_W-1:0] = '0;
                  1: wdata[MINS_W-1:0] = '1;
                  default: ;
               endcase
               write_reg(CSR_MIN_SPIN, wdata);
            end
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            pick_twist(lin, ang);
            send_twist(lin, ang);
         end
      end

      // Drain, then watch for stray results
      settle_pipeline();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("twist_to_speed_radius_command_core_test: clean");
      end else begin
         $display("twist_to_speed_radius_command_core_test: errors");
      end
      $finish;
   end

endmodule
